// ===== src/lira_pkg.sv =====
// shared types and constants for the linear interpolation audio resampler
`timescale 1ns / 1ps
`default_nettype none

package lira_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_RESULTS  = 64;
   localparam int SAMPLE_W     = 16;
   localparam int CHAN_OUT_W   = 3;
   localparam int STEP_W       = 23;
   localparam int CHCNT_W      = 4;
   localparam int FRAMES_W     = 24;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;

   localparam logic [STEP_W-1:0]  STEP_RESET  = 23'd65536;
   localparam logic [CHCNT_W-1:0] CHCNT_RESET = 4'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_RATIO    = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1,
      CSR_OUTPUT_FRAMES = 2'd2,
      CSR_BYPASS        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       final_in;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic [CHAN_OUT_W-1:0]      chan_out;
      logic                       run_end;
      logic                       stream_done;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== src/linear_interp_audio_resampler.sv =====
// linear interpolation audio resampler: sequencer, sample store and output buffer
// an input word passes start, the copy of output 0 if it carries one, then check,
// multiply and lerp per interpolated result, update, read and emit per flush result
// and finish; bypass words pass the bypass and finish states; the sequencer shares
// one multiply unit; results leave via a one-word hold stage and an output register
// reset is synchronous: registers to defaults, stream state and held samples to zero
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_audio_resampler #(
   parameter int MAX_CHANNELS = lira_pkg::MAX_CHANNELS,
   parameter int FRAC_BITS    = lira_pkg::FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lira_pkg::req_word_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lira_pkg::rsp_word_type                   rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [lira_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lira_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SW     = lira_pkg::SAMPLE_W;
   localparam int FW     = lira_pkg::FRAMES_W;
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
   localparam int NW     = (NCH_W > lira_pkg::CHCNT_W) ? NCH_W : lira_pkg::CHCNT_W;
   localparam int PH_W   = FRAC_BITS + 31;
   localparam int CNT_W  = $clog2(lira_pkg::MAX_RESULTS + 1);
   localparam logic [FW-1:0] FRAME_MAX = {FW{1'b1}};

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_BYP   = 11'b000_0000_0010,
      S_START = 11'b000_0000_0100,
      S_COPY  = 11'b000_0000_1000,
      S_CHECK = 11'b000_0001_0000,
      S_MUL   = 11'b000_0010_0000,
      S_LERP  = 11'b000_0100_0000,
      S_UPD   = 11'b000_1000_0000,
      S_FRD   = 11'b001_0000_0000,
      S_FEMIT = 11'b010_0000_0000,
      S_FIN   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [lira_pkg::STEP_W-1:0]  step_ratio_ff, step_ratio_in;
   logic [lira_pkg::CHCNT_W-1:0] channel_count_ff, channel_count_in;
   logic [FW-1:0]                output_frames_ff, output_frames_in;
   logic                         bypass_ff, bypass_in;

   logic [PH_W-1:0]   frame_phase_ff, frame_phase_in;
   logic [FW-1:0]     frame_start_count_ff, frame_start_count_in;
   logic [FW-1:0]     in_frame_count_ff, in_frame_count_in;
   logic [CH_W-1:0]   chan_index_ff, chan_index_in;
   logic [PH_W-1:0]   phase_acc_ff, phase_acc_in;
   logic [FW-1:0]     out_count_ff, out_count_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [MAX_CHANNELS-1:0] vld_ff, vld_in;

   logic signed [SW-1:0] cur_ff, cur_in;
   logic signed [SW-1:0] prev_ff, prev_in;
   logic                 is_final_ff, is_final_in;
   logic [CH_W-1:0]      c_ff, c_in;

   logic                   pend_valid_ff, pend_valid_in;
   lira_pkg::rsp_word_type pend_data_ff, pend_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lira_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   // per-channel sample store
   logic signed [SW-1:0] prev_mem [MAX_CHANNELS];
   logic signed [SW-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [CH_W-1:0]      rd_addr;
   logic                 rd_en;
   logic                 mem_we;

   logic [NW-1:0]        cc_w;
   logic [NW-1:0]        nch;
   logic [NW-1:0]        chan_w;
   logic [CH_W-1:0]      c_comb;
   logic [PH_W-1:0]      step_w;
   logic [PH_W-1:0]      step_sat;
   logic [PH_W-1:0]      end_pos;
   logic                 slot_free;
   logic                 can_go;
   logic                 c_last;
   logic                 ch_last;
   logic                 frame_last;
   logic signed [SW-1:0] held;
   logic signed [SW-1:0] flush_sample;
   logic signed [SW-1:0] lerp_result;
   logic                 mul_en;
   logic                 produce;
   lira_pkg::rsp_word_type new_word;

   lira_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock  (clock),
      .mul_en (mul_en),
      .a      (prev_ff),
      .b      (cur_ff),
      .frac   (phase_acc_ff[FRAC_BITS-1:0]),
      .result (lerp_result)
   );

   // channel count clamped to 1..MAX_CHANNELS, sample channel to the last one
   always_comb begin
      cc_w = NW'(channel_count_ff);
      if (cc_w == '0) begin
         nch = NW'(1);
      end else if (cc_w > NW'(MAX_CHANNELS)) begin
         nch = NW'(MAX_CHANNELS);
      end else begin
         nch = cc_w;
      end
      chan_w = NW'(chan_index_ff);
      if (chan_w >= nch) begin
         c_comb = CH_W'(nch - NW'(1));
      end else begin
         c_comb = chan_index_ff;
      end
   end

   // step saturated to 1/32 .. 64 frames
   always_comb begin
      step_w = PH_W'(step_ratio_ff);
      if (step_w < (PH_W'(1) << (FRAC_BITS - 5))) begin
         step_sat = PH_W'(1) << (FRAC_BITS - 5);
      end else if (step_w > (PH_W'(64) << FRAC_BITS)) begin
         step_sat = PH_W'(64) << FRAC_BITS;
      end else begin
         step_sat = step_w;
      end
   end

   assign end_pos    = PH_W'(in_frame_count_ff) << FRAC_BITS;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign can_go     = !pend_valid_ff || slot_free;
   assign c_last     = (NW'(c_ff) + NW'(1)) >= nch;
   assign ch_last    = (NW'(ch_ff) + NW'(1)) >= nch;
   assign frame_last = ({1'b0, out_count_ff} + (FW + 1)'(1)) == {1'b0, output_frames_ff};

   assign held = rd_vld_ff ? rd_data_ff : '0;
   // flush copy sitting exactly on the last input frame rounds like f = 0
   assign flush_sample = (phase_acc_ff == end_pos && held < 0) ? held + SW'(1) : held;

   assign rd_en   = (state_ff == S_IDLE) || (state_ff == S_FRD);
   assign rd_addr = (state_ff == S_IDLE) ? c_comb : ch_ff;

   always_comb begin
      state_in             = state_ff;
      step_ratio_in        = step_ratio_ff;
      channel_count_in     = channel_count_ff;
      output_frames_in     = output_frames_ff;
      bypass_in            = bypass_ff;
      frame_phase_in       = frame_phase_ff;
      frame_start_count_in = frame_start_count_ff;
      in_frame_count_in    = in_frame_count_ff;
      chan_index_in        = chan_index_ff;
      phase_acc_in         = phase_acc_ff;
      out_count_in         = out_count_ff;
      cnt_in               = cnt_ff;
      ch_in                = ch_ff;
      vld_in               = vld_ff;
      cur_in               = cur_ff;
      prev_in              = prev_ff;
      is_final_in          = is_final_ff;
      c_in                 = c_ff;
      pend_valid_in        = pend_valid_ff;
      pend_data_in         = pend_data_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_data_in          = rsp_data_ff;
      mem_we               = 1'b0;
      mul_en               = 1'b0;
      produce              = 1'b0;
      new_word             = '0;

      if (csr_we) begin
         unique case (lira_pkg::csr_index_type'(csr_index))
            lira_pkg::CSR_STEP_RATIO:    step_ratio_in    = csr_wdata[lira_pkg::STEP_W-1:0];
            lira_pkg::CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[lira_pkg::CHCNT_W-1:0];
            lira_pkg::CSR_OUTPUT_FRAMES: output_frames_in = csr_wdata[FW-1:0];
            lira_pkg::CSR_BYPASS:        bypass_in        = csr_wdata[0];
            default:                     bypass_in        = bypass_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_in      = req_data.sample_in;
               is_final_in = req_data.final_in;
               c_in        = c_comb;
               state_in    = bypass_ff ? S_BYP : S_START;
            end
         end
         S_BYP: begin
            if (can_go) begin
               produce              = 1'b1;
               new_word.sample_out  = cur_ff;
               new_word.chan_out    = lira_pkg::CHAN_OUT_W'(c_ff);
               new_word.stream_done = is_final_ff;
               mem_we               = 1'b1;
               state_in             = S_FIN;
            end
         end
         S_START: begin
            prev_in      = held;
            out_count_in = frame_start_count_ff;
            phase_acc_in = frame_phase_ff;
            cnt_in       = '0;
            if (in_frame_count_ff == '0 && frame_start_count_ff == '0 &&
                output_frames_ff != '0) begin
               state_in = S_COPY;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_COPY: begin
            // output 0 copies input frame 0
            if (can_go) begin
               produce              = 1'b1;
               new_word.sample_out  = cur_ff;
               new_word.chan_out    = lira_pkg::CHAN_OUT_W'(c_ff);
               new_word.stream_done = frame_last && c_last;
               out_count_in         = FW'(1);
               phase_acc_in         = step_sat;
               cnt_in               = CNT_W'(1);
               state_in             = S_CHECK;
            end
         end
         S_CHECK: begin
            if (out_count_ff < output_frames_ff && phase_acc_ff < end_pos &&
                cnt_ff < CNT_W'(lira_pkg::MAX_RESULTS)) begin
               state_in = S_MUL;
            end else begin
               state_in = S_UPD;
            end
         end
         S_MUL: begin
            mul_en   = 1'b1;
            state_in = S_LERP;
         end
         S_LERP: begin
            if (can_go) begin
               produce              = 1'b1;
               new_word.sample_out  = lerp_result;
               new_word.chan_out    = lira_pkg::CHAN_OUT_W'(c_ff);
               new_word.stream_done = frame_last && c_last;
               out_count_in         = out_count_ff + FW'(1);
               phase_acc_in         = phase_acc_ff + step_sat;
               cnt_in               = cnt_ff + CNT_W'(1);
               state_in             = S_CHECK;
            end
         end
         S_UPD: begin
            mem_we = 1'b1;
            if (is_final_ff && out_count_ff < output_frames_ff &&
                cnt_ff < CNT_W'(lira_pkg::MAX_RESULTS)) begin
               ch_in    = '0;
               state_in = S_FRD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FRD: begin
            state_in = S_FEMIT;
         end
         S_FEMIT: begin
            // flush walks frame by frame over all channels
            if (can_go) begin
               produce              = 1'b1;
               new_word.sample_out  = flush_sample;
               new_word.chan_out    = lira_pkg::CHAN_OUT_W'(ch_ff);
               new_word.stream_done = frame_last && ch_last;
               cnt_in               = cnt_ff + CNT_W'(1);
               if (ch_last) begin
                  ch_in        = '0;
                  out_count_in = out_count_ff + FW'(1);
                  phase_acc_in = phase_acc_ff + step_sat;
               end else begin
                  ch_in = ch_ff + CH_W'(1);
               end
               if ((cnt_ff + CNT_W'(1)) < CNT_W'(lira_pkg::MAX_RESULTS) &&
                   (!ch_last || (out_count_ff + FW'(1)) < output_frames_ff)) begin
                  state_in = S_FRD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (can_go) begin
               if (pend_valid_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in          = pend_data_ff;
                  rsp_data_in.run_end  = 1'b1;
               end
               pend_valid_in = 1'b0;
               if (is_final_ff) begin
                  frame_phase_in       = '0;
                  frame_start_count_in = '0;
                  in_frame_count_in    = '0;
                  chan_index_in        = '0;
                  phase_acc_in         = '0;
                  out_count_in         = '0;
                  vld_in               = '0;
               end else if (c_last) begin
                  if (!bypass_ff) begin
                     frame_phase_in       = phase_acc_ff;
                     frame_start_count_in = out_count_ff;
                  end
                  if (in_frame_count_ff != FRAME_MAX) begin
                     in_frame_count_in = in_frame_count_ff + FW'(1);
                  end
                  chan_index_in = '0;
               end else begin
                  chan_index_in = c_ff + CH_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mem_we) begin
         vld_in[c_ff] = 1'b1;
      end

      // a new word pushes the held one out, which therefore was not the last
      if (produce) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pend_data_ff;
         end
         pend_valid_in = 1'b1;
         pend_data_in  = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         step_ratio_ff        <= lira_pkg::STEP_RESET;
         channel_count_ff     <= lira_pkg::CHCNT_RESET;
         output_frames_ff     <= '0;
         bypass_ff            <= 1'b0;
         frame_phase_ff       <= '0;
         frame_start_count_ff <= '0;
         in_frame_count_ff    <= '0;
         chan_index_ff        <= '0;
         phase_acc_ff         <= '0;
         out_count_ff         <= '0;
         cnt_ff               <= '0;
         ch_ff                <= '0;
         vld_ff               <= '0;
         rd_vld_ff            <= 1'b0;
         pend_valid_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         step_ratio_ff        <= step_ratio_in;
         channel_count_ff     <= channel_count_in;
         output_frames_ff     <= output_frames_in;
         bypass_ff            <= bypass_in;
         frame_phase_ff       <= frame_phase_in;
         frame_start_count_ff <= frame_start_count_in;
         in_frame_count_ff    <= in_frame_count_in;
         chan_index_ff        <= chan_index_in;
         phase_acc_ff         <= phase_acc_in;
         out_count_ff         <= out_count_in;
         cnt_ff               <= cnt_in;
         ch_ff                <= ch_in;
         vld_ff               <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
         pend_valid_ff        <= pend_valid_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      is_final_ff  <= is_final_in;
      c_ff         <= c_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prev_mem[c_ff] <= cur_ff;
      end
      if (rd_en) begin
         rd_data_ff <= prev_mem[rd_addr];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("held word left behind when going idle");

   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(lira_pkg::MAX_RESULTS))
      else $error("result count above limit");

   a_start_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !bypass_ff) |=> (state_ff == S_START))
      else $error("accepted word did not start the sequence");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && pend_valid_ff && slot_free) |=> (rsp_valid && rsp_data.run_end))
      else $error("closing word not marked as run end");

endmodule

`default_nettype wire

// ===== src/lira_lerp.sv =====
// two-stage interpolation unit: registered multiply, then add one half and truncate toward zero
`timescale 1ns / 1ps
`default_nettype none

module lira_lerp #(
   parameter int FRAC_BITS = lira_pkg::FRAC_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 mul_en,
   input  wire logic signed [lira_pkg::SAMPLE_W-1:0] a,
   input  wire logic signed [lira_pkg::SAMPLE_W-1:0] b,
   input  wire logic [FRAC_BITS-1:0]                 frac,
   output logic signed [lira_pkg::SAMPLE_W-1:0]      result
);

   localparam int DIFF_W = lira_pkg::SAMPLE_W + 1;
   localparam int PROD_W = FRAC_BITS + DIFF_W + 1;
   localparam int VW     = PROD_W + 1;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VW-1:0]     a_scaled;
   logic signed [VW-1:0]     half;
   logic signed [VW-1:0]     sum;
   logic signed [VW-1:0]     bias;
   logic signed [VW-1:0]     rounded;

   assign diff    = DIFF_W'(b) - DIFF_W'(a);
   assign prod_in = PROD_W'($signed({1'b0, frac}) * diff);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign a_scaled = VW'(a) <<< FRAC_BITS;
   assign half     = VW'(1) <<< (FRAC_BITS - 1);
   assign sum      = a_scaled + VW'(prod_ff) + half;
   // bias a negative sum so the arithmetic shift truncates toward zero
   assign bias     = sum[VW-1] ? ((VW'(1) <<< FRAC_BITS) - VW'(1)) : '0;
   assign rounded  = (sum + bias) >>> FRAC_BITS;
   assign result   = rounded[lira_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== tb/lira_stream_checker.sv =====
// checker for the resampler: watches both channels and the csr port, predicts and compares
`timescale 1ns / 1ps

module lira_stream_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire lira_pkg::req_word_type              req_data,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire lira_pkg::rsp_word_type              rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [lira_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lira_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                       fail_count,
   output int                                       pending_words
);
   import lira_pkg::*;

   localparam longint unsigned STEP_MIN  = (64'd1 << FRAC_BITS) >> 5;
   localparam longint unsigned STEP_MAX  = 64'd64 << FRAC_BITS;
   localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
   localparam int unsigned     FRAME_MAX = 32'h00FF_FFFF;

   // register copies
   logic [STEP_W-1:0]   step_reg;
   logic [CHCNT_W-1:0]  chcnt_reg;
   logic [FRAMES_W-1:0] frames_reg;
   logic                bypass_reg;

   // stream state
   logic signed [SAMPLE_W-1:0] held [MAX_CHANNELS];
   longint unsigned frame_pos;
   int unsigned     frame_first;
   int unsigned     in_frames;
   int unsigned     next_chan;

   rsp_word_type expected_words [$];

   function automatic void clear_stream();
      for (int i = 0; i < MAX_CHANNELS; i++) held[i] = '0;
      frame_pos   = 0;
      frame_first = 0;
      in_frames   = 0;
      next_chan   = 0;
   endfunction

   // a + f*(b-a) + 0.5, truncated toward zero
   function automatic logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                                        logic signed [SAMPLE_W-1:0] b,
                                                        longint unsigned frac);
      longint one;
      longint v;
      one = longint'(1) << FRAC_BITS;
      v = longint'(a) * one + longint'(frac) * (longint'(b) - longint'(a)) + one / 2;
      v = v / one;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic void push_sample(logic signed [SAMPLE_W-1:0] s, int unsigned ch,
                                       int unsigned k, int unsigned nch);
      rsp_word_type w;
      w.sample_out  = s;
      w.chan_out    = ch[CHAN_OUT_W-1:0];
      w.run_end     = 1'b0;
      w.stream_done = (k + 1 == frames_reg) && (ch + 1 == nch);
      expected_words.push_back(w);
   endfunction

   function automatic void predict_outputs(req_word_type in_word);
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] s;
      logic                       last;
      int unsigned                nch, c, k, m, cnt;
      longint unsigned            step, ph, stop;
      rsp_word_type               w;
      x    = in_word.sample_in;
      last = in_word.final_in;
      nch  = chcnt_reg;
      if (nch < 1) nch = 1;
      if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
      c = next_chan;
      if (c >= nch) c = nch - 1;
      step = step_reg;
      if (step < STEP_MIN) step = STEP_MIN;
      if (step > STEP_MAX) step = STEP_MAX;
      m   = frames_reg;
      cnt = 0;

      if (bypass_reg) begin
         w.sample_out  = x;
         w.chan_out    = c[CHAN_OUT_W-1:0];
         w.run_end     = 1'b1;
         w.stream_done = last;
         expected_words.push_back(w);
         held[c] = x;
         if (last) begin
            clear_stream();
         end else if (c + 1 >= nch) begin
            next_chan = 0;
            if (in_frames < FRAME_MAX) in_frames++;
         end else begin
            next_chan = c + 1;
         end
         return;
      end

      k  = frame_first;
      ph = frame_pos;
      // output 0 is a copy of input frame 0
      if (in_frames == 0 && k == 0 && m > 0) begin
         push_sample(x, c, 0, nch);
         cnt++;
         k  = 1;
         ph = step;
      end
      stop = longint'(in_frames) << FRAC_BITS;
      while (k < m && ph < stop && cnt < MAX_RESULTS) begin
         push_sample(blend(held[c], x, ph & FRAC_MASK), c, k, nch);
         cnt++;
         k++;
         ph += step;
      end
      held[c] = x;

      if (last) begin
         // flush the rest as copies of the held samples, frame by frame
         while (k < m && cnt < MAX_RESULTS) begin
            for (int unsigned ch = 0; ch < nch && cnt < MAX_RESULTS; ch++) begin
               s = held[ch];
               if (ph == stop && s < 0) s = s + 1;
               push_sample(s, ch, k, nch);
               cnt++;
            end
            k++;
            ph += step;
         end
         clear_stream();
      end else if (c + 1 >= nch) begin
         frame_pos   = ph;
         frame_first = k;
         if (in_frames < FRAME_MAX) in_frames++;
         next_chan = 0;
      end else begin
         next_chan = c + 1;
      end

      if (cnt > 0) begin
         w = expected_words.pop_back();
         w.run_end = 1'b1;
         expected_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         step_reg   = STEP_RESET;
         chcnt_reg  = CHCNT_RESET;
         frames_reg = '0;
         bypass_reg = 1'b0;
         clear_stream();
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_RATIO:    step_reg   = csr_wdata[STEP_W-1:0];
               CSR_CHANNEL_COUNT: chcnt_reg  = csr_wdata[CHCNT_W-1:0];
               CSR_OUTPUT_FRAMES: frames_reg = csr_wdata[FRAMES_W-1:0];
               CSR_BYPASS:        bypass_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result word: sample %0d chan %0d run_end %b done %b",
                           $realtime, rsp_data.sample_out, rsp_data.chan_out,
                           rsp_data.run_end, rsp_data.stream_done);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.sample_out !== want.sample_out || rsp_data.chan_out !== want.chan_out ||
                   rsp_data.run_end !== want.run_end ||
                   rsp_data.stream_done !== want.stream_done) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch: expected sample %0d chan %0d run_end %b done %b, got sample %0d chan %0d run_end %b done %b",
                              $realtime, want.sample_out, want.chan_out, want.run_end,
                              want.stream_done, rsp_data.sample_out, rsp_data.chan_out,
                              rsp_data.run_end, rsp_data.stream_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_outputs(req_data);
      end
      pending_words = expected_words.size();
   end

endmodule

// ===== tb/tb_linear_interp_audio_resampler.sv =====
// top of the resampler testbench: clock, reset, stimulus, result pacing and verdict
`timescale 1ns / 1ps

module tb_linear_interp_audio_resampler;
   import lira_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_WORDS  = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_STEP_RATIO;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_words;
   int cycle_count = 0;
   int words_sent  = 0;
   int ready_left  = 0;
   int pace_pick;
   logic quiet      = 1'b0;
   logic rsp_stalls = 1'b1;

   linear_interp_audio_resampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lira_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side back-pressure: mostly ready, short stalls, now and then a long one
   always @(negedge clock) begin
      if (ready_left > 0) begin
         ready_left--;
      end else if (!rsp_stalls) begin
         rsp_ready <= 1'b1;
      end else begin
         pace_pick = $urandom_range(0, 99);
         if (pace_pick < 60) begin
            rsp_ready <= 1'b1;
            ready_left = $urandom_range(0, 6);
         end else if (pace_pick < 92) begin
            rsp_ready <= 1'b0;
            ready_left = $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b0;
            ready_left = $urandom_range(5, 20);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      int unsigned u;
      u = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return u[SAMPLE_W-1:0];
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic signed [SAMPLE_W-1:0] value, input logic last);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= {value, last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int unsigned step, input int unsigned chans,
                            input int unsigned frames, input int unsigned byp);
      csr_we    <= 1'b1;
      csr_index <= CSR_STEP_RATIO;
      csr_wdata <= step[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= chans[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_OUTPUT_FRAMES;
      csr_wdata <= frames[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_BYPASS;
      csr_wdata <= byp[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // cut >= 0 puts an early final on that word and ends the stream there
   task automatic send_stream(input int frames, input int chans, input int cut);
      int last_idx;
      last_idx = (cut >= 0) ? cut : frames * chans - 1;
      for (int i = 0; i <= last_idx; i++) begin
         send_word(rand_sample(), i == last_idx);
         if (i != last_idx && $urandom_range(0, 39) == 0) drain();
      end
   endtask

   initial begin : stimulus
      int unsigned step, chans, frames, byp, eff_chans;
      int          mode, nwords, first_random;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: zero output frames gives no results
      send_word(16'sh7FFF, 1'b0);
      send_word(16'sh8000, 1'b1);
      drain();

      // step below range, channel count 0
      configure(0, 0, 5, 0);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh7FFF, 1'b1);
      drain();

      // step above range, channel count above max, early final in frame 0
      configure(23'h7FFFFF, 15, 3, 0);
      send_word(16'sd1234, 1'b0);
      send_word(-16'sd1, 1'b0);
      send_word(16'sh8000, 1'b1);
      drain();

      // channel count lowered mid-frame, flush right at the last frame, long flush
      configure(65536, 4, 100, 0);
      send_word(16'sd100, 1'b0);
      send_word(-16'sd200, 1'b0);
      send_word(16'sd300, 1'b0);
      drain();
      configure(65536, 2, 100, 0);
      send_word(-16'sd400, 1'b0);
      send_word(-16'sd7, 1'b0);
      send_word(16'sh8000, 1'b1);
      drain();

      // bypass across a frame boundary
      configure(65536, 3, 4, 1);
      send_word(16'sd1, 1'b0);
      send_word(-16'sd1, 1'b0);
      send_word(16'sd0, 1'b0);
      send_word(-16'sd2, 1'b1);
      drain();

      // interpolation with an early final in frame 1
      configure(40000, 3, 7, 0);
      send_stream(2, 3, 4);
      drain();

      first_random = words_sent;
      while (words_sent - first_random < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0: step = 2048;
            1: step = 4194304;
            2: step = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(4194305, 8388607);
            3, 4, 5: step = $urandom_range(2048, 65536);
            default: step = $urandom_range(65536, 300000);
         endcase
         chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0: frames = 0;
            1: frames = $urandom_range(0, 16777215);
            default: frames = $urandom_range(1, 60);
         endcase
         byp = ($urandom_range(0, 5) == 0) ? 1 : 0;
         eff_chans = (chans == 0) ? 1 : (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;

         drain();
         configure(step, chans, frames, byp);
         quiet      = ($urandom_range(0, 3) == 0);
         rsp_stalls = ($urandom_range(0, 3) != 0);

         repeat ($urandom_range(1, 3)) begin
            mode = $urandom_range(0, 99);
            if (mode < 75) begin
               send_stream($urandom_range(1, 6), eff_chans, -1);
            end else if (mode < 90) begin
               send_stream(3, eff_chans, $urandom_range(0, 3 * eff_chans - 1));
            end else begin
               // loose words with stray finals, closed by a final
               nwords = $urandom_range(1, 6);
               for (int i = 0; i < nwords; i++)
                  send_word(rand_sample(), (i == nwords - 1) || ($urandom_range(0, 9) < 3));
            end
         end
      end

      drain();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
